### rtl/aen_pkg.sv
`timescale 1ns / 1ps

package aen_pkg;

	// field widths
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned VER_W = 7;
	localparam int unsigned Q_W = 14;

	// pattern set: gzip, br, star, identity
	localparam int unsigned PAT_COUNT = 4;
	localparam int unsigned PAT_MAX = 8;
	localparam int unsigned PROG_W = 4;
	localparam int unsigned P_GZIP = 0;
	localparam int unsigned P_BR = 1;
	localparam int unsigned P_STAR = 2;
	localparam int unsigned P_ID = 3;

	localparam logic [PROG_W-1:0] PAT_LEN [PAT_COUNT] = '{4'd4, 4'd2, 4'd1, 4'd8};
	localparam logic [BYTE_W-1:0] PAT_TEXT [PAT_COUNT][PAT_MAX] = '{
		'{"g", "z", "i", "p", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"b", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"*", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"i", "d", "e", "n", "t", "i", "t", "y"}
	};

	// characters of the q-value syntax
	localparam logic [BYTE_W-1:0] CH_SPACE = " ";
	localparam logic [BYTE_W-1:0] CH_COMMA = ",";
	localparam logic [BYTE_W-1:0] CH_SEMI = ";";
	localparam logic [BYTE_W-1:0] CH_Q = "q";
	localparam logic [BYTE_W-1:0] CH_EQ = "=";
	localparam logic [BYTE_W-1:0] CH_DOT = ".";
	localparam logic [BYTE_W-1:0] CH_ZERO = "0";
	localparam logic [BYTE_W-1:0] CH_NINE = "9";
	localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;

	// q-value in thousandths
	localparam logic [Q_W-1:0] Q_ONE = 14'd1000;
	localparam logic [VER_W-1:0] VER_MIN = 7'd11;

	localparam int unsigned QUEUE_DEPTH = 2;

	// q-value parser phase
	typedef enum logic [9:0] {
		PH_IDLE  = 10'b00_0000_0001,
		PH_SEMI  = 10'b00_0000_0010,
		PH_Q     = 10'b00_0000_0100,
		PH_EQ    = 10'b00_0000_1000,
		PH_INT   = 10'b00_0001_0000,
		PH_DOT   = 10'b00_0010_0000,
		PH_FRAC0 = 10'b00_0100_0000,
		PH_FRAC  = 10'b00_1000_0000,
		PH_TERM  = 10'b01_0000_0000,
		PH_DONE  = 10'b10_0000_0000
	} qphase_t;

	// byte classification made by the front end
	typedef struct packed {
		logic is_space;
		logic is_semi;
		logic is_q;
		logic is_eq;
		logic is_dot;
		logic is_digit;
		logic is_term;
		logic [3:0] digit;
		logic [PAT_COUNT-1:0][PAT_MAX-1:0] pos_eq;
	} class_t;

	// one queued item
	typedef struct packed {
		class_t cls;
		logic last;
		logic ver_ok;
	} item_t;

	// next matched prefix length of pattern p; eq marks pattern positions equal to the byte
	function automatic logic [PROG_W-1:0] advance(input int unsigned p,
			input logic [PROG_W-1:0] prog, input logic [PAT_MAX-1:0] eq);
		logic [PROG_W-1:0] cur;
		logic [PROG_W-1:0] nxt;
		logic pre;
		int idx;
		cur = (prog >= PAT_LEN[p]) ? '0 : prog;
		nxt = '0;
		for (int k = 1; k <= PAT_MAX; k++) begin
			pre = 1'b1;
			for (int j = 0; j < PAT_MAX - 1; j++) begin
				idx = int'(cur) - k + 1 + j;
				if (j < k - 1 && idx >= 0 && idx < PAT_MAX) begin
					if (PAT_TEXT[p][j] != PAT_TEXT[p][idx[2:0]])
						pre = 1'b0;
				end
			end
			if (k <= int'(cur) + 1 && eq[k-1] && pre)
				nxt = PROG_W'(k);
		end
		return nxt;
	endfunction

endpackage

### rtl/aen_hdr_if.sv
`timescale 1ns / 1ps

interface aen_hdr_if;
	import aen_pkg::*;

	logic valid;
	logic ready;
	logic [BYTE_W-1:0] header_byte;
	logic last_byte;
	logic [VER_W-1:0] http_version_x10;

	modport source (output valid, header_byte, last_byte, http_version_x10, input ready);
	modport sink (input valid, header_byte, last_byte, http_version_x10, output ready);
endinterface

### rtl/aen_res_if.sv
`timescale 1ns / 1ps

interface aen_res_if;
	logic valid;
	logic ready;
	logic gzip_accept;
	logic brotli_accept;

	modport source (output valid, gzip_accept, brotli_accept, input ready);
	modport sink (input valid, gzip_accept, brotli_accept, output ready);
endinterface

### rtl/accept_encoding_negotiator.sv
// a last byte passes through the queue, the decision stage register and the output register before its result is valid
// throughput: one header byte per cycle; while a result waits to be taken, bytes keep
// flowing and one more finished header is held, the last byte after that one stalls
// a queue of QUEUE_DEPTH bytes sits between the classifier and the matchers
// reset (asynchronous, active low) empties the queue, drops any pending result and
// returns all matchers and q-value parsers to the start of a header
`timescale 1ns / 1ps

module accept_encoding_negotiator #(
	parameter int unsigned QUEUE_DEPTH = aen_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	aen_hdr_if.sink hdr,
	aen_res_if.source res
);
	import aen_pkg::*;

	logic push_valid;
	logic push_ready;
	item_t push_item;
	logic pop_valid;
	logic pop_ready;
	item_t pop_item;

	// classify incoming bytes
	aen_front u_front (
		.hdr(hdr),
		.push_ready(push_ready),
		.push_valid(push_valid),
		.push_item(push_item)
	);

	// decoupling queue
	aen_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item(push_item),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_item(pop_item)
	);

	// matchers, q-value parsers and decision
	aen_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_item(pop_item),
		.res(res)
	);

endmodule

### rtl/aen_front.sv
`timescale 1ns / 1ps

module aen_front (
	aen_hdr_if.sink hdr,
	input logic push_ready,
	output logic push_valid,
	output aen_pkg::item_t push_item
);
	import aen_pkg::*;

	logic [BYTE_W-1:0] c;

	assign c = hdr.header_byte;
	assign push_valid = hdr.valid;
	assign hdr.ready = push_ready;

	// character classes for the q-value parsers
	always_comb begin
		push_item = '0;
		push_item.cls.is_space = (c == CH_SPACE);
		push_item.cls.is_semi = (c == CH_SEMI);
		push_item.cls.is_q = (c == CH_Q);
		push_item.cls.is_eq = (c == CH_EQ);
		push_item.cls.is_dot = (c == CH_DOT);
		push_item.cls.is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
		push_item.cls.is_term = (c == CH_SPACE) || (c == CH_COMMA) || (c == CH_SEMI)
			|| (c == CH_NUL);
		push_item.cls.digit = 4'(c - CH_ZERO);
		// pattern positions holding this character
		for (int p = 0; p < PAT_COUNT; p++) begin
			for (int k = 0; k < PAT_MAX; k++) begin
				push_item.cls.pos_eq[p][k] = (PROG_W'(k) < PAT_LEN[p]) && (c == PAT_TEXT[p][k]);
			end
		end
		push_item.last = hdr.last_byte;
		push_item.ver_ok = (hdr.http_version_x10 >= VER_MIN);
	end

endmodule

### rtl/aen_queue.sv
`timescale 1ns / 1ps

module aen_queue #(
	parameter int unsigned DEPTH = aen_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic push_valid,
	output logic push_ready,
	input aen_pkg::item_t push_item,
	output logic pop_valid,
	input logic pop_ready,
	output aen_pkg::item_t pop_item
);
	import aen_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	item_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic push;
	logic pop;

	assign push_ready = (cnt_q != FULL_CNT);
	assign pop_valid = (cnt_q != '0);
	assign pop_item = mem_q[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

### rtl/aen_back.sv
`timescale 1ns / 1ps

module aen_back (
	input logic clk,
	input logic arst_n,
	input logic pop_valid,
	output logic pop_ready,
	input aen_pkg::item_t pop_item,
	aen_res_if.source res
);
	import aen_pkg::*;

	// per-pattern matcher and q-value state
	logic [PROG_W-1:0] prog_q [PAT_COUNT];
	logic [PAT_COUNT-1:0] found_q;
	qphase_t ph_q [PAT_COUNT];
	logic [Q_W-1:0] qv_q [PAT_COUNT];
	logic [PAT_COUNT-1:0] given_q;
	logic [1:0] fd_q [PAT_COUNT];

	logic [PROG_W-1:0] prog_d [PAT_COUNT];
	logic [PAT_COUNT-1:0] found_d;
	qphase_t ph_d [PAT_COUNT];
	logic [Q_W-1:0] qv_d [PAT_COUNT];
	logic [PAT_COUNT-1:0] given_d;
	logic [1:0] fd_d [PAT_COUNT];
	logic [Q_W-1:0] qfin [PAT_COUNT];

	// decision stage
	logic dec_v_s1;
	logic [PAT_COUNT-1:0] found_s1;
	logic [Q_W-1:0] q_s1 [PAT_COUNT];
	logic ver_ok_s1;

	logic out_v_q;
	logic gz_q;
	logic br_q;

	logic pop;
	logic out_ld;
	logic dec_ready;
	logic gz;
	logic br;
	class_t cls;

	assign cls = pop_item.cls;
	assign out_ld = !out_v_q || res.ready;
	assign dec_ready = !dec_v_s1 || out_ld;
	assign pop_ready = !pop_item.last || dec_ready;
	assign pop = pop_valid && pop_ready;

	// matcher advance and q-value parser step
	always_comb begin
		logic [1:0] n;
		n = '0;
		prog_d = prog_q;
		found_d = found_q;
		ph_d = ph_q;
		qv_d = qv_q;
		given_d = given_q;
		fd_d = fd_q;
		for (int p = 0; p < PAT_COUNT; p++) begin
			if (found_q[p]) begin
				case (ph_q[p])
					PH_SEMI, PH_Q, PH_EQ, PH_INT: begin
						if (!cls.is_space) begin
							if (ph_q[p] == PH_SEMI && cls.is_semi)
								ph_d[p] = PH_Q;
							else if (ph_q[p] == PH_Q && cls.is_q)
								ph_d[p] = PH_EQ;
							else if (ph_q[p] == PH_EQ && cls.is_eq)
								ph_d[p] = PH_INT;
							else if (ph_q[p] == PH_INT && cls.is_digit) begin
								qv_d[p] = Q_W'(cls.digit) * Q_W'(1000);
								ph_d[p] = PH_DOT;
							end else begin
								given_d[p] = 1'b0;
								qv_d[p] = Q_ONE;
								ph_d[p] = PH_DONE;
							end
						end
					end
					PH_DOT: begin
						if (cls.is_dot)
							ph_d[p] = PH_FRAC0;
						else if (cls.is_term) begin
							given_d[p] = 1'b1;
							ph_d[p] = PH_DONE;
						end else begin
							given_d[p] = 1'b0;
							qv_d[p] = Q_ONE;
							ph_d[p] = PH_DONE;
						end
					end
					PH_FRAC0, PH_FRAC: begin
						if (cls.is_digit) begin
							n = (ph_q[p] == PH_FRAC0) ? 2'd0 : fd_q[p];
							case (n)
								2'd0: qv_d[p] = qv_q[p] + Q_W'(cls.digit) * Q_W'(100);
								2'd1: qv_d[p] = qv_q[p] + Q_W'(cls.digit) * Q_W'(10);
								default: qv_d[p] = qv_q[p] + Q_W'(cls.digit);
							endcase
							fd_d[p] = n + 2'd1;
							ph_d[p] = (n >= 2'd2) ? PH_TERM : PH_FRAC;
						end else if (cls.is_term) begin
							given_d[p] = 1'b1;
							ph_d[p] = PH_DONE;
						end else begin
							given_d[p] = 1'b0;
							qv_d[p] = Q_ONE;
							ph_d[p] = PH_DONE;
						end
					end
					PH_TERM: begin
						if (cls.is_term)
							given_d[p] = 1'b1;
						else begin
							given_d[p] = 1'b0;
							qv_d[p] = Q_ONE;
						end
						ph_d[p] = PH_DONE;
					end
					default: begin
					end
				endcase
			end else begin
				prog_d[p] = advance(p, prog_q[p], cls.pos_eq[p]);
				if (prog_d[p] == PAT_LEN[p]) begin
					found_d[p] = 1'b1;
					ph_d[p] = PH_SEMI;
				end
			end
		end
	end

	// q-value seen at end of header
	always_comb begin
		for (int p = 0; p < PAT_COUNT; p++) begin
			if (ph_d[p] == PH_DOT || ph_d[p] == PH_FRAC0 || ph_d[p] == PH_FRAC
					|| ph_d[p] == PH_TERM || (ph_d[p] == PH_DONE && given_d[p]))
				qfin[p] = qv_d[p];
			else
				qfin[p] = Q_ONE;
		end
	end

	// state update, back to start after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= '0;
			given_q <= '0;
			for (int p = 0; p < PAT_COUNT; p++) begin
				prog_q[p] <= '0;
				ph_q[p] <= PH_IDLE;
				qv_q[p] <= Q_ONE;
				fd_q[p] <= '0;
			end
		end else if (pop) begin
			if (pop_item.last) begin
				found_q <= '0;
				given_q <= '0;
				for (int p = 0; p < PAT_COUNT; p++) begin
					prog_q[p] <= '0;
					ph_q[p] <= PH_IDLE;
					qv_q[p] <= Q_ONE;
					fd_q[p] <= '0;
				end
			end else begin
				found_q <= found_d;
				given_q <= given_d;
				prog_q <= prog_d;
				ph_q <= ph_d;
				qv_q <= qv_d;
				fd_q <= fd_d;
			end
		end
	end

	// decision stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dec_v_s1 <= 1'b0;
		else if (dec_ready)
			dec_v_s1 <= pop && pop_item.last;
	end

	// snapshot of the finished header
	always_ff @(posedge clk) begin
		if (pop && pop_item.last && dec_ready) begin
			found_s1 <= found_d;
			q_s1 <= qfin;
			ver_ok_s1 <= pop_item.ver_ok;
		end
	end

	function automatic logic compress_ok(input logic f, input logic [Q_W-1:0] q,
			input logic id_f, input logic [Q_W-1:0] id_q,
			input logic st_f, input logic [Q_W-1:0] st_q);
		logic ok;
		if (!f)
			ok = 1'b0;
		else if (q >= Q_ONE)
			ok = 1'b1;
		else if (q == '0)
			ok = 1'b0;
		else if (id_f)
			ok = (q >= id_q);
		else if (st_f)
			ok = (q >= st_q);
		else
			ok = 1'b1;
		return ok;
	endfunction

	// accept decisions
	always_comb begin
		if (found_s1[P_GZIP] || found_s1[P_BR]) begin
			gz = compress_ok(found_s1[P_GZIP], q_s1[P_GZIP], found_s1[P_ID], q_s1[P_ID],
				found_s1[P_STAR], q_s1[P_STAR]);
			br = compress_ok(found_s1[P_BR], q_s1[P_BR], found_s1[P_ID], q_s1[P_ID],
				found_s1[P_STAR], q_s1[P_STAR]);
		end else if (found_s1[P_STAR]) begin
			if (q_s1[P_STAR] == '0)
				gz = 1'b0;
			else if (found_s1[P_ID])
				gz = (q_s1[P_STAR] >= q_s1[P_ID]) && ver_ok_s1;
			else
				gz = ver_ok_s1;
			br = gz;
		end else begin
			gz = 1'b0;
			br = 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (out_ld)
			out_v_q <= dec_v_s1;
	end

	always_ff @(posedge clk) begin
		if (out_ld && dec_v_s1) begin
			gz_q <= gz;
			br_q <= br;
		end
	end

	assign res.valid = out_v_q;
	assign res.gzip_accept = gz_q;
	assign res.brotli_accept = br_q;

endmodule

### rtl/aen_checker.sv
`timescale 1ns / 1ps

module aen_checker (
	input logic clk,
	input logic arst_n,
	input logic hdr_valid,
	input logic hdr_ready,
	input logic hdr_last,
	input logic res_valid,
	input logic res_ready,
	input logic res_gzip,
	input logic res_brotli
);

	logic [7:0] pend_q;
	logic hdr_end;
	logic res_xfer;

	assign hdr_end = hdr_valid && hdr_ready && hdr_last;
	assign res_xfer = res_valid && res_ready;

	// headers ended but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= '0;
		else if (hdr_end && !res_xfer)
			pend_q <= pend_q + 1'b1;
		else if (res_xfer && !hdr_end)
			pend_q <= pend_q - 1'b1;
	end

	// a result only follows a header end
	a_res_has_header: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pend_q != '0)
		else $error("result without a finished header");

	// no result once reset has been seen at an edge
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !res_valid)
		else $error("result valid during reset");

	// stalled result stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// stalled result keeps its value
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_gzip) && $stable(res_brotli))
		else $error("result changed while stalled");

endmodule

bind accept_encoding_negotiator aen_checker u_aen_checker (
	.clk(clk),
	.arst_n(arst_n),
	.hdr_valid(hdr.valid),
	.hdr_ready(hdr.ready),
	.hdr_last(hdr.last_byte),
	.res_valid(res.valid),
	.res_ready(res.ready),
	.res_gzip(res.gzip_accept),
	.res_brotli(res.brotli_accept)
);

### bench/negotiation_checker.sv
`timescale 1ns / 1ps

module negotiation_checker (
	input logic clk,
	input logic arst_n,
	aen_hdr_if hdr,
	aen_res_if res,
	output int unsigned mismatches,
	output int unsigned pending,
	output int unsigned checked
);
	import aen_pkg::*;

	typedef struct packed {
		logic gzip;
		logic brotli;
	} verdict_t;

	// verdicts still owed by the block, oldest first
	verdict_t verdict_q [$];

	// per-coding matcher and q-value parser state
	logic [PROG_W-1:0] prefix_len [PAT_COUNT];
	logic found [PAT_COUNT];
	qphase_t qphase [PAT_COUNT];
	logic [Q_W-1:0] q_mil [PAT_COUNT];
	logic q_given [PAT_COUNT];
	logic [1:0] frac_cnt [PAT_COUNT];

	task automatic clear_state();
		for (int p = 0; p < PAT_COUNT; p++) begin
			prefix_len[p] = '0;
			found[p] = 1'b0;
			qphase[p] = PH_IDLE;
			q_mil[p] = Q_ONE;
			q_given[p] = 1'b0;
			frac_cnt[p] = '0;
		end
	endtask

	function automatic logic is_delim(input logic [BYTE_W-1:0] c);
		return c == CH_SPACE || c == CH_COMMA || c == CH_SEMI || c == CH_NUL;
	endfunction

	function automatic logic is_num(input logic [BYTE_W-1:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	// longest prefix of the coding name that ends at this byte
	function automatic logic [PROG_W-1:0] next_prefix(input int p,
			input logic [PROG_W-1:0] prev, input logic [BYTE_W-1:0] c);
		int cur;
		logic ok;
		cur = (prev >= PAT_LEN[p]) ? 0 : int'(prev);
		if (PAT_TEXT[p][cur] == c)
			return PROG_W'(cur + 1);
		for (int k = cur; k >= 1; k--) begin
			ok = PAT_TEXT[p][k-1] == c;
			for (int j = 0; j < k - 1; j++)
				if (PAT_TEXT[p][j] != PAT_TEXT[p][cur-k+1+j])
					ok = 1'b0;
			if (ok)
				return PROG_W'(k);
		end
		return '0;
	endfunction

	task automatic q_take(input int p);
		q_given[p] = 1'b1;
		qphase[p] = PH_DONE;
	endtask

	task automatic q_reject(input int p);
		q_given[p] = 1'b0;
		q_mil[p] = Q_ONE;
		qphase[p] = PH_DONE;
	endtask

	// one byte through the q-value parser of a coding already seen
	task automatic parse_q(input int p, input logic [BYTE_W-1:0] c);
		int d;
		int n;
		d = int'(c) - int'(CH_ZERO);
		if (c == CH_SPACE && (qphase[p] == PH_SEMI || qphase[p] == PH_Q ||
				qphase[p] == PH_EQ || qphase[p] == PH_INT))
			return;
		case (qphase[p])
			PH_SEMI: begin
				if (c == CH_SEMI) qphase[p] = PH_Q;
				else q_reject(p);
			end
			PH_Q: begin
				if (c == CH_Q) qphase[p] = PH_EQ;
				else q_reject(p);
			end
			PH_EQ: begin
				if (c == CH_EQ) qphase[p] = PH_INT;
				else q_reject(p);
			end
			PH_INT: begin
				if (is_num(c)) begin
					q_mil[p] = Q_W'(d * 1000);
					qphase[p] = PH_DOT;
				end else
					q_reject(p);
			end
			PH_DOT: begin
				if (c == CH_DOT) qphase[p] = PH_FRAC0;
				else if (is_delim(c)) q_take(p);
				else q_reject(p);
			end
			PH_FRAC0, PH_FRAC: begin
				if (is_num(c)) begin
					n = (qphase[p] == PH_FRAC0) ? 0 : int'(frac_cnt[p]);
					if (n == 0) q_mil[p] = q_mil[p] + Q_W'(d * 100);
					else if (n == 1) q_mil[p] = q_mil[p] + Q_W'(d * 10);
					else q_mil[p] = q_mil[p] + Q_W'(d);
					frac_cnt[p] = 2'(n + 1);
					qphase[p] = (n >= 2) ? PH_TERM : PH_FRAC;
				end else if (is_delim(c))
					q_take(p);
				else
					q_reject(p);
			end
			PH_TERM: begin
				if (is_delim(c)) q_take(p);
				else q_reject(p);
			end
			default: ;
		endcase
	endtask

	// q-value in force when the header ends
	function automatic int settled_q(input int p);
		if (qphase[p] == PH_DOT || qphase[p] == PH_FRAC0 || qphase[p] == PH_FRAC ||
				qphase[p] == PH_TERM)
			return int'(q_mil[p]);
		if (qphase[p] == PH_DONE && q_given[p])
			return int'(q_mil[p]);
		return int'(Q_ONE);
	endfunction

	function automatic logic scheme_ok(input logic f, input int q, input logic id_f,
			input int id_q, input logic star_f, input int star_q);
		if (!f) return 1'b0;
		if (q >= int'(Q_ONE)) return 1'b1;
		if (q == 0) return 1'b0;
		if (id_f) return q >= id_q;
		if (star_f) return q >= star_q;
		return 1'b1;
	endfunction

	// advance all matchers by one byte; the last byte yields a verdict
	task automatic take_byte(input logic [BYTE_W-1:0] c, input logic last,
			input logic [VER_W-1:0] ver);
		int q [PAT_COUNT];
		verdict_t v;
		for (int p = 0; p < PAT_COUNT; p++) begin
			if (found[p])
				parse_q(p, c);
			else begin
				prefix_len[p] = next_prefix(p, prefix_len[p], c);
				if (prefix_len[p] == PAT_LEN[p]) begin
					found[p] = 1'b1;
					qphase[p] = PH_SEMI;
				end
			end
		end
		if (!last)
			return;
		for (int p = 0; p < PAT_COUNT; p++)
			q[p] = settled_q(p);
		if (found[P_GZIP] || found[P_BR]) begin
			v.gzip = scheme_ok(found[P_GZIP], q[P_GZIP], found[P_ID], q[P_ID],
				found[P_STAR], q[P_STAR]);
			v.brotli = scheme_ok(found[P_BR], q[P_BR], found[P_ID], q[P_ID],
				found[P_STAR], q[P_STAR]);
		end else if (found[P_STAR]) begin
			// star alone stands for both codings
			if (q[P_STAR] == 0) v.gzip = 1'b0;
			else if (found[P_ID]) v.gzip = q[P_STAR] >= q[P_ID] && ver >= VER_MIN;
			else v.gzip = ver >= VER_MIN;
			v.brotli = v.gzip;
		end else
			v = '0;
		verdict_q.push_back(v);
		clear_state();
	endtask

	initial begin
		clear_state();
		mismatches = 0;
		pending = 0;
		checked = 0;
	end

	// compare each verdict transfer, then predict from each byte transfer
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n) begin
			if (res.valid && res.ready) begin
				if (verdict_q.size() == 0) begin
					$display("%0t: unexpected verdict gzip=%b br=%b", $time,
						res.gzip_accept, res.brotli_accept);
					mismatches++;
				end else begin
					want = verdict_q.pop_front();
					checked++;
					if (res.gzip_accept !== want.gzip) begin
						$display("%0t: gzip_accept expected %b got %b", $time,
							want.gzip, res.gzip_accept);
						mismatches++;
					end
					if (res.brotli_accept !== want.brotli) begin
						$display("%0t: brotli_accept expected %b got %b", $time,
							want.brotli, res.brotli_accept);
						mismatches++;
					end
				end
			end
			if (hdr.valid && hdr.ready)
				take_byte(hdr.header_byte, hdr.last_byte, hdr.http_version_x10);
			pending = verdict_q.size();
		end
	end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import aen_pkg::*;

	localparam int unsigned ITEM_TARGET = 1650;
	localparam int unsigned CALM_AFTER = 1400;

	logic clk;
	logic arst_n;

	aen_hdr_if hdr ();
	aen_res_if res ();

	int unsigned mismatches;
	int unsigned pending;
	int unsigned checked;
	int unsigned bytes_sent;
	int unsigned headers_sent;
	bit calm;
	int gap_rate;
	logic [BYTE_W-1:0] hdr_text [$];

	string coding_names [12] = '{"gzip", "br", "*", "identity", "deflate", "x-gzip",
		"gzi", "identit", "ggzip", "bbr", "idgzip", "identitygzip"};

	accept_encoding_negotiator dut (
		.clk(clk),
		.arst_n(arst_n),
		.hdr(hdr),
		.res(res)
	);

	negotiation_checker verdict_check (
		.clk(clk),
		.arst_n(arst_n),
		.hdr(hdr),
		.res(res),
		.mismatches(mismatches),
		.pending(pending),
		.checked(checked)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// one byte transfer, with an optional gap before it
	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last,
			input logic [VER_W-1:0] ver);
		@(negedge clk);
		if (!calm && gap_rate != 0 && $urandom_range(0, 7) < gap_rate) begin
			hdr.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		hdr.valid <= 1'b1;
		hdr.header_byte <= b;
		hdr.last_byte <= last;
		hdr.http_version_x10 <= ver;
		do @(posedge clk); while (!hdr.ready);
		bytes_sent++;
		if (bytes_sent >= CALM_AFTER)
			calm = 1'b1;
	endtask

	task automatic send_header(input logic [VER_W-1:0] ver);
		for (int i = 0; i < hdr_text.size(); i++) begin
			if (i == hdr_text.size() - 1)
				send_byte(hdr_text[i], 1'b1, ver);
			else
				send_byte(hdr_text[i], 1'b0, VER_W'($urandom_range(0, 99)));
		end
		headers_sent++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			hdr_text.push_back(s[i]);
	endtask

	task automatic add_spaces();
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 2)) hdr_text.push_back(CH_SPACE);
	endtask

	function automatic logic [BYTE_W-1:0] rand_digit();
		return CH_ZERO + BYTE_W'($urandom_range(0, 9));
	endfunction

	task automatic add_separator();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5)
			hdr_text.push_back(CH_COMMA);
		else if (r < 7) begin
			hdr_text.push_back(CH_COMMA);
			hdr_text.push_back(CH_SPACE);
		end else if (r == 7)
			hdr_text.push_back(CH_SPACE);
		else if (r == 8)
			hdr_text.push_back(CH_SEMI);
		else
			hdr_text.push_back(CH_NUL);
	endtask

	// coding name, near miss, or raw junk
	task automatic add_coding();
		int k;
		k = $urandom_range(0, 12);
		if (k == 12)
			repeat ($urandom_range(1, 3)) hdr_text.push_back(BYTE_W'($urandom_range(0, 255)));
		else
			push_text(coding_names[k]);
	endtask

	// ";q=D.FFF" with random spacing, sometimes cut short, too long or damaged
	task automatic add_qvalue();
		int start;
		int r;
		start = hdr_text.size();
		add_spaces();
		hdr_text.push_back(CH_SEMI);
		add_spaces();
		hdr_text.push_back(CH_Q);
		add_spaces();
		hdr_text.push_back(CH_EQ);
		add_spaces();
		r = $urandom_range(0, 9);
		if (r < 4) hdr_text.push_back(CH_ZERO);
		else if (r < 8) hdr_text.push_back(CH_ZERO + 8'd1);
		else hdr_text.push_back(rand_digit());
		if ($urandom_range(0, 3) != 0) begin
			hdr_text.push_back(CH_DOT);
			repeat ($urandom_range(0, 4)) hdr_text.push_back(rand_digit());
		end
		if ($urandom_range(0, 9) == 0)
			hdr_text[$urandom_range(start, hdr_text.size() - 1)] =
				BYTE_W'($urandom_range(0, 255));
	endtask

	task automatic build_header();
		int n_el;
		hdr_text.delete();
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 12)) hdr_text.push_back(BYTE_W'($urandom_range(0, 255)));
			return;
		end
		n_el = $urandom_range(1, 4);
		for (int i = 0; i < n_el; i++) begin
			if (i != 0)
				add_separator();
			add_coding();
			if ($urandom_range(0, 9) < 6)
				add_qvalue();
		end
		if ($urandom_range(0, 7) == 0)
			add_separator();
	endtask

	function automatic logic [VER_W-1:0] pick_version();
		if ($urandom_range(0, 1) == 0)
			return VER_W'($urandom_range(9, 12));
		return VER_W'($urandom_range(0, 99));
	endfunction

	// verdict side: stall bursts, with quiet stretches
	initial begin
		int stall_left;
		int span;
		bit busy;
		res.ready = 1'b0;
		stall_left = 0;
		span = 0;
		busy = 1'b1;
		forever begin
			@(negedge clk);
			if (span == 0) begin
				span = 128;
				busy = $urandom_range(0, 2) != 0;
			end
			span--;
			if (stall_left == 0 && busy && !calm && $urandom_range(0, 9) == 0)
				stall_left = $urandom_range(1, 8);
			if (stall_left != 0) begin
				res.ready <= 1'b0;
				stall_left--;
			end else
				res.ready <= 1'b1;
		end
	end

	// byte side: reset, directed headers, random headers, drain
	initial begin
		hdr.valid = 1'b0;
		hdr.header_byte = '0;
		hdr.last_byte = 1'b0;
		hdr.http_version_x10 = '0;
		arst_n = 1'b0;
		calm = 1'b0;
		gap_rate = 0;
		bytes_sent = 0;
		headers_sent = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// byte extremes, star vs version, match on the final byte,
		// zero q, nul ending a number, header ending while a q-value is awaited
		hdr_text = '{CH_NUL};
		send_header(VER_W'(0));
		hdr_text = '{8'hFF};
		send_header(VER_W'(99));
		hdr_text.delete();
		push_text("*");
		send_header(VER_MIN);
		hdr_text.delete();
		push_text("*");
		send_header(VER_W'(VER_MIN - 1'b1));
		hdr_text.delete();
		push_text("br");
		send_header(VER_W'(99));
		hdr_text.delete();
		push_text("*;q=0");
		send_header(VER_MIN);
		hdr_text.delete();
		push_text("br;q=0");
		hdr_text.push_back(CH_NUL);
		send_header(VER_MIN);
		hdr_text.delete();
		push_text("gzip;");
		send_header(VER_MIN);

		// random headers
		while (bytes_sent < ITEM_TARGET) begin
			build_header();
			gap_rate = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
			send_header(pick_version());
		end

		@(negedge clk);
		hdr.valid <= 1'b0;
		wait (pending == 0);
		repeat (8) @(posedge clk);

		$display("covered %0d header bytes in %0d headers, %0d verdicts compared",
			bytes_sent, headers_sent, checked);
		if (mismatches == 0)
			$display("accept_encoding_negotiator verification clean");
		else
			$display("accept_encoding_negotiator verification failed");
		$finish;
	end

	// hang guard
	initial begin
		#20_000_000;
		$display("accept_encoding_negotiator verification failed");
		$finish;
	end

endmodule
